### sv/apq_pkg.sv
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types and constants for the array priority queue: operation and
// status codes, sequencer states and default sizing.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int unsigned APQ_DEPTH    = 16;
  localparam int unsigned ELEM_W       = 32;
  localparam int unsigned PRIO_W       = 16;
  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned ENTRY_W      = ELEM_W + PRIO_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ = 2'd0,
    FUNC_DEQ = 2'd1,
    FUNC_CLR = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_e;

endpackage

### sv/apq_ram.sv
// ----------------------------------------------------------------------------
// apq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module apq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/array_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// array_priority_queue_unit
// Bounded priority queue kept as an unsorted array in arrival order. A
// dequeue scans for the highest priority (earliest wins ties), removes it and
// closes the gap.
//
//   Channel | Dir | Handshake                | Payload
//   --------+-----+--------------------------+----------------------------------------
//   in      | in  | in_valid_i, in_stall_o   | func, element, priority_req
//   out     | out | out_valid_o, out_stall_i | status, out_element, out_priority, count
//
// Enqueue, clear and failed dequeue go straight to the output register. A
// successful dequeue scans all n held entries for the winner at index b, moves
// the entries behind it down one place unless b = n - 1, then loads the output;
// the scan and the compaction share the single read port of the entry RAM.
// Reset clears the fill count and the sequencer; the RAM needs no clearing.
// A stalled output holds its result and the input is stalled until it leaves.
// ----------------------------------------------------------------------------
module array_priority_queue_unit #(
  parameter int unsigned DEPTH = apq_pkg::APQ_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [apq_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [apq_pkg::ELEM_W-1:0] element_i,
  input  logic signed [apq_pkg::PRIO_W-1:0] priority_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [apq_pkg::STATUS_W-1:0]      status_o,
  output logic signed [apq_pkg::ELEM_W-1:0] out_element_o,
  output logic signed [apq_pkg::PRIO_W-1:0] out_priority_o,
  output logic [apq_pkg::COUNT_W-1:0]       count_o
);

  import apq_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e state_q, state_d;

  logic [CW-1:0]      fill_q, fill_d;
  logic [CW-1:0]      rd_cnt_q, rd_cnt_d;
  logic [CW-1:0]      pipe_idx_q, pipe_idx_d;
  logic               pipe_valid_q, pipe_valid_d;
  logic [CW-1:0]      best_idx_q, best_idx_d;
  logic signed [PRIO_W-1:0] best_prio_q, best_prio_d;
  logic signed [ELEM_W-1:0] best_elem_q, best_elem_d;

  logic               out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic signed [ELEM_W-1:0] out_elem_q, out_elem_d;
  logic signed [PRIO_W-1:0] out_prio_q, out_prio_d;
  logic [COUNT_W-1:0] count_q, count_d;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               accept;
  logic               out_free;
  logic               is_full;
  logic               is_empty;
  logic [CW-1:0]      fill_last;
  logic               issue;
  logic signed [PRIO_W-1:0] rd_prio;
  logic signed [ELEM_W-1:0] rd_elem;
  logic               take_new;
  logic [CW-1:0]      best_idx_fin;
  logic               last_data;
  logic [CW-1:0]      wr_idx;
  func_e              func;

  apq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign func      = func_e'(func_i);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept    = in_valid_i && !in_stall_o;
  assign is_full   = (fill_q == CW'(DEPTH));
  assign is_empty  = (fill_q == '0);
  assign fill_last = fill_q - CW'(1);
  assign issue     = (rd_cnt_q < fill_q);
  assign rd_prio   = ram_rdata[PRIO_W-1:0];
  assign rd_elem   = ram_rdata[ENTRY_W-1:PRIO_W];
  assign wr_idx    = pipe_idx_q - CW'(1);

  // The first entry read always seeds the running maximum; a strict compare
  // keeps the earliest entry on equal priorities.
  assign take_new     = pipe_valid_q && ((pipe_idx_q == '0) || (rd_prio > best_prio_q));
  assign best_idx_fin = take_new ? pipe_idx_q : best_idx_q;
  assign last_data    = pipe_valid_q && (pipe_idx_q == fill_last);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (func == FUNC_DEQ) && !is_empty) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_data) begin
          state_d = (best_idx_fin == fill_last) ? S_RESULT : S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (last_data) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    fill_d       = fill_q;
    rd_cnt_d     = rd_cnt_q;
    pipe_idx_d   = rd_cnt_q;
    pipe_valid_d = 1'b0;
    best_idx_d   = best_idx_q;
    best_prio_d  = best_prio_q;
    best_elem_d  = best_elem_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    out_elem_d   = out_elem_q;
    out_prio_d   = out_prio_q;
    count_d      = count_q;
    ram_we       = 1'b0;
    ram_waddr    = fill_q[IW-1:0];
    ram_wdata    = {element_i, priority_req_i};
    ram_raddr    = rd_cnt_q[IW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          status_d    = ST_DONE;
          out_elem_d  = '0;
          out_prio_d  = '0;
          unique case (func)
            FUNC_ENQ: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                ram_we = 1'b1;
                fill_d = fill_q + CW'(1);
              end
            end
            FUNC_DEQ: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                rd_cnt_d    = '0;
              end
            end
            FUNC_CLR: begin
              fill_d = '0;
            end
            default: begin
            end
          endcase
          count_d = COUNT_W'(fill_d);
        end
      end
      S_SCAN, S_SHIFT: begin
        if (issue) begin
          pipe_valid_d = 1'b1;
          rd_cnt_d     = rd_cnt_q + CW'(1);
        end
        if (state_q == S_SCAN) begin
          if (take_new) begin
            best_idx_d  = pipe_idx_q;
            best_prio_d = rd_prio;
            best_elem_d = rd_elem;
          end
          // Compaction starts reading just past the winner.
          if (last_data) begin
            rd_cnt_d = best_idx_fin + CW'(1);
          end
        end else if (pipe_valid_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_idx[IW-1:0];
          ram_wdata = ram_rdata;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          fill_d      = fill_q - CW'(1);
          out_valid_d = 1'b1;
          status_d    = ST_DONE;
          out_elem_d  = best_elem_q;
          out_prio_d  = best_prio_q;
          count_d     = COUNT_W'(fill_d);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      rd_cnt_q     <= '0;
      pipe_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      rd_cnt_q     <= rd_cnt_d;
      pipe_valid_q <= pipe_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_idx_q  <= pipe_idx_d;
    best_idx_q  <= best_idx_d;
    best_prio_q <= best_prio_d;
    best_elem_q <= best_elem_d;
    status_q    <= status_d;
    out_elem_q  <= out_elem_d;
    out_prio_q  <= out_prio_d;
    count_q     <= count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_element_o  = out_elem_q;
  assign out_priority_o = out_prio_q;
  assign count_o        = count_q;

endmodule
